// ----- sv/pits_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants of the point-in-triangle set unit
package pits_pkg;

  localparam int COORD_W       = 32;
  localparam int DIFF_W        = COORD_W + 1;
  localparam int MAG_W         = COORD_W;
  localparam int PROD_W        = 2 * MAG_W;
  localparam int ACC_W         = PROD_W + 2;
  localparam int EPS_W         = 16;
  localparam int OP_W          = 2;
  localparam int WORDS_PER_TRI = 6;
  localparam int ROW_W         = COORD_W * WORDS_PER_TRI;
  localparam int STEP_W        = 3;

  localparam logic [EPS_W-1:0] EPS_RESET = 16'd168;

  // operation codes of an input word
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  // word positions inside one stored triangle row
  localparam int W_AX = 0;
  localparam int W_AY = 1;
  localparam int W_BX = 2;
  localparam int W_BY = 3;
  localparam int W_CX = 4;
  localparam int W_CY = 5;

  // the four cross products of one triangle: origin vertex, then edge end
  localparam logic [1:0] X_A_B = 2'd0;
  localparam logic [1:0] X_A_C = 2'd1;
  localparam logic [1:0] X_B_A = 2'd2;
  localparam logic [1:0] X_B_C = 2'd3;

  localparam logic [STEP_W-1:0] STEP_LAST = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_RUN,
    ST_DRAIN,
    ST_RESP
  } state_t;

  // one product issued to the shared unit
  typedef struct packed {
    logic       vld;
    logic [1:0] sel;
    logic       term;
  } step_t;

  // sign class of one finished cross product
  typedef struct packed {
    logic       vld;
    logic [1:0] sel;
    logic       pos;
    logic       neg;
  } cls_t;

endpackage

// ----- sv/pits_ram.sv -----
`timescale 1ns / 1ps
// generic single-port-write, single-port-read ram with registered read
module pits_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/pits_cross_unit.sv -----
`timescale 1ns / 1ps
// shared cross product pipeline: magnitude, 32x32 multiply, accumulate, classify
module pits_cross_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  pits_pkg::step_t                    step,
  input  logic signed [pits_pkg::DIFF_W-1:0] diff_a,
  input  logic signed [pits_pkg::DIFF_W-1:0] diff_b,
  input  logic [pits_pkg::EPS_W-1:0]         eps,
  output logic                               busy,
  output pits_pkg::cls_t                     cls
);

  pits_pkg::step_t s1, s2, s3, s4;

  logic signed [pits_pkg::DIFF_W-1:0] s1_a, s1_b;
  logic [pits_pkg::MAG_W-1:0]         s2_ma, s2_mb;
  logic                               s2_neg;
  logic [pits_pkg::PROD_W-1:0]        s3_prod;
  logic                               s3_neg;
  logic signed [pits_pkg::ACC_W-1:0]  acc;

  logic [pits_pkg::DIFF_W-1:0]        neg_a, neg_b;
  logic [pits_pkg::PROD_W-1:0]        prod_full;
  logic signed [pits_pkg::ACC_W-1:0]  prod_ext, acc_next;
  logic signed [pits_pkg::ACC_W-1:0]  eps_s, eps_n;
  logic                               zero;

  // stage 2: magnitudes, a difference never exceeds 2^32-1 in size
  assign neg_a = -s1_a;
  assign neg_b = -s1_b;

  // stage 3: the one multiplier
  assign prod_full = s2_ma * s2_mb;

  // stage 4: signed accumulate, first term loads, second term is subtracted
  assign prod_ext = $signed({2'b00, s3_prod});
  always_comb begin
    if (!s3.term) begin
      acc_next = s3_neg ? -prod_ext : prod_ext;
    end else begin
      acc_next = s3_neg ? (acc - prod_ext) : (acc + prod_ext);
    end
  end

  // stage 5: below epsilon in size counts as zero
  assign eps_s = $signed({{(pits_pkg::ACC_W - pits_pkg::EPS_W){1'b0}}, eps});
  assign eps_n = -eps_s;
  assign zero  = (acc == '0) || ((acc < eps_s) && (acc > eps_n));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1  <= '0;
      s2  <= '0;
      s3  <= '0;
      s4  <= '0;
      cls <= '0;
    end else begin
      s1      <= step;
      s2      <= s1;
      s3      <= s2;
      s4      <= s3;
      cls.vld <= s4.vld & s4.term;
      cls.sel <= s4.sel;
      cls.pos <= !zero && !acc[pits_pkg::ACC_W-1];
      cls.neg <= !zero && acc[pits_pkg::ACC_W-1];
    end
  end

  always_ff @(posedge clk) begin
    s1_a    <= diff_a;
    s1_b    <= diff_b;
    s2_ma   <= s1_a[pits_pkg::DIFF_W-1] ? neg_a[pits_pkg::MAG_W-1:0]
                                        : s1_a[pits_pkg::MAG_W-1:0];
    s2_mb   <= s1_b[pits_pkg::DIFF_W-1] ? neg_b[pits_pkg::MAG_W-1:0]
                                        : s1_b[pits_pkg::MAG_W-1:0];
    s2_neg  <= s1_a[pits_pkg::DIFF_W-1] ^ s1_b[pits_pkg::DIFF_W-1] ^ s1.term;
    s3_prod <= prod_full;
    s3_neg  <= s2_neg;
    if (s3.vld) begin
      acc <= acc_next;
    end
  end

  assign busy = s1.vld | s2.vld | s3.vld | s4.vld | cls.vld;

endmodule

// ----- sv/point_in_triangle_set_unit.sv -----
`timescale 1ns / 1ps
// top level of the point-in-triangle set unit: table, sequencer, handshakes
//
// Holds up to MAX_TRIANGLES triangles in a ram of one 192-bit row per triangle
// and answers whether a query point lies strictly inside any of them. A clear
// word (op 0) empties the table and returns nothing; op 3 is ignored. A load
// word (op 1) writes one row and returns one word, table_full set if the
// table was already full and the triangle dropped. A query word (op 2)
// returns one word with is_inside. A query walks the stored triangles one
// after another through a single shared 32x32 multiplier: each triangle
// needs four cross products of two products each, so the multiplier sets the
// pace of the walk.
// The next triangle's row is read from the ram while the current one is still
// being issued, so the multiplier never idles during a walk. The input side
// is not ready while a query is being worked on; a finished result sits in an
// output register so that the next word can be taken while it waits. A cross
// product whose size is below the eps register (written through the cfg port,
// reset 168, Q.24 units) counts as zero, so points on an edge are outside.
// The ram needs no clearing pass: only rows below the fill count are read.
module point_in_triangle_set_unit #(
  parameter int MAX_TRIANGLES = 128
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pits_pkg::EPS_W-1:0]          cfg_data,
  // input words
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [pits_pkg::OP_W-1:0]           op,
  input  logic signed [pits_pkg::COORD_W-1:0] x0,
  input  logic signed [pits_pkg::COORD_W-1:0] y0,
  input  logic signed [pits_pkg::COORD_W-1:0] x1,
  input  logic signed [pits_pkg::COORD_W-1:0] y1,
  input  logic signed [pits_pkg::COORD_W-1:0] x2,
  input  logic signed [pits_pkg::COORD_W-1:0] y2,
  // result words
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                is_inside,
  output logic                                table_full
);

  localparam int IDX_W = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
  localparam int CNT_W = $clog2(MAX_TRIANGLES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TRIANGLES);

  pits_pkg::state_t state, state_next;

  // table fill and walk position
  logic [CNT_W-1:0]                   count;
  logic [CNT_W-1:0]                   tri_cnt;
  logic [CNT_W-1:0]                   tri_next;
  logic [pits_pkg::STEP_W-1:0]        step_cnt;
  logic                               more;
  logic                               full;

  logic [pits_pkg::EPS_W-1:0]         eps;
  logic signed [pits_pkg::COORD_W-1:0] px, py;

  // pending result, held until the output register is free
  logic                               res_inside;
  logic                               res_full;

  // first-of-pair sign class and first test outcome of the current triangle
  logic                               g_pos, g_neg;
  logic                               test_a;
  logic                               between;

  logic                               in_acc;
  logic                               slot_free;

  // ram ports
  logic                               we, re;
  logic [IDX_W-1:0]                   raddr;
  logic [pits_pkg::ROW_W-1:0]         wdata, row;

  // operand selection
  pits_pkg::step_t                    step;
  pits_pkg::cls_t                     cls;
  logic                               pipe_busy;
  logic signed [pits_pkg::DIFF_W-1:0] ax, ay, bx, by, cx, cy;
  logic signed [pits_pkg::DIFF_W-1:0] ox, oy, wx, wy, pxe, pye;
  logic signed [pits_pkg::DIFF_W-1:0] diff_a, diff_b;

  assign in_ready  = (state == pits_pkg::ST_IDLE);
  assign in_acc    = in_valid & in_ready;
  assign cfg_ready = 1'b1;
  assign slot_free = !out_valid || out_ready;

  assign full     = (count == CNT_MAX);
  assign tri_next = tri_cnt + CNT_W'(1);
  assign more     = (tri_next < count);

  // ---------------------------------------------------------------- table
  assign we    = in_acc && (op == pits_pkg::OP_LOAD) && !full;
  assign wdata = {y2, x2, y1, x1, y0, x0};
  assign re    = (state == pits_pkg::ST_FETCH) ||
                 ((state == pits_pkg::ST_RUN) && (step_cnt == pits_pkg::STEP_LAST) && more);
  // prefetch of the next row lands on the same edge as the last step's issue
  assign raddr = (state == pits_pkg::ST_FETCH) ? '0 : tri_next[IDX_W-1:0];

  pits_ram #(
    .WIDTH (pits_pkg::ROW_W),
    .DEPTH (MAX_TRIANGLES)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (count[IDX_W-1:0]),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (row)
  );

  // ---------------------------------------------------------------- operands
  assign ax  = $signed({row[pits_pkg::W_AX*32+31], row[pits_pkg::W_AX*32 +: 32]});
  assign ay  = $signed({row[pits_pkg::W_AY*32+31], row[pits_pkg::W_AY*32 +: 32]});
  assign bx  = $signed({row[pits_pkg::W_BX*32+31], row[pits_pkg::W_BX*32 +: 32]});
  assign by  = $signed({row[pits_pkg::W_BY*32+31], row[pits_pkg::W_BY*32 +: 32]});
  assign cx  = $signed({row[pits_pkg::W_CX*32+31], row[pits_pkg::W_CX*32 +: 32]});
  assign cy  = $signed({row[pits_pkg::W_CY*32+31], row[pits_pkg::W_CY*32 +: 32]});
  assign pxe = $signed({px[pits_pkg::COORD_W-1], px});
  assign pye = $signed({py[pits_pkg::COORD_W-1], py});

  assign step.vld  = (state == pits_pkg::ST_RUN);
  assign step.sel  = step_cnt[2:1];
  assign step.term = step_cnt[0];

  // origin is vertex a for the first test, b for the second
  assign ox = step.sel[1] ? bx : ax;
  assign oy = step.sel[1] ? by : ay;
  // edge end: c for the second cross product of each test, else the other vertex
  assign wx = step.sel[0] ? cx : (step.sel[1] ? ax : bx);
  assign wy = step.sel[0] ? cy : (step.sel[1] ? ay : by);

  // cross = mx*wy' - my*wx'; the second term is subtracted inside the unit
  assign diff_a = step.term ? (pye - oy) : (pxe - ox);
  assign diff_b = step.term ? (wx - ox) : (wy - oy);

  pits_cross_unit u_cross (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .diff_a (diff_a),
    .diff_b (diff_b),
    .eps    (eps),
    .busy   (pipe_busy),
    .cls    (cls)
  );

  // strictly between: the edge cross products of the pair have opposite nonzero signs
  assign between = (g_neg & cls.pos) | (g_pos & cls.neg);

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pits_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pits_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (op)
            pits_pkg::OP_LOAD:  state_next = pits_pkg::ST_RESP;
            pits_pkg::OP_QUERY: state_next = (count == '0) ? pits_pkg::ST_RESP
                                                           : pits_pkg::ST_FETCH;
            default:            state_next = pits_pkg::ST_IDLE;
          endcase
        end
      end
      pits_pkg::ST_FETCH: state_next = pits_pkg::ST_RUN;
      pits_pkg::ST_RUN: begin
        if ((step_cnt == pits_pkg::STEP_LAST) && !more) begin
          state_next = pits_pkg::ST_DRAIN;
        end
      end
      pits_pkg::ST_DRAIN: begin
        if (!pipe_busy) begin
          state_next = pits_pkg::ST_RESP;
        end
      end
      pits_pkg::ST_RESP: begin
        if (slot_free) begin
          state_next = pits_pkg::ST_IDLE;
        end
      end
      default: state_next = pits_pkg::ST_IDLE;
    endcase
  end

  // control state: fill count, walk position, epsilon, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      tri_cnt   <= '0;
      step_cnt  <= '0;
      eps       <= pits_pkg::EPS_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        eps <= cfg_data;
      end
      if (in_acc && (op == pits_pkg::OP_CLEAR)) begin
        count <= '0;
      end else if (we) begin
        count <= count + CNT_W'(1);
      end
      if (in_acc) begin
        tri_cnt <= '0;
      end else if (re && (state == pits_pkg::ST_RUN)) begin
        tri_cnt <= tri_next;
      end
      if (state == pits_pkg::ST_FETCH) begin
        step_cnt <= '0;
      end else if (state == pits_pkg::ST_RUN) begin
        step_cnt <= step_cnt + pits_pkg::STEP_W'(1);
      end
      if ((state == pits_pkg::ST_RESP) && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload: query point, pending result, per-triangle test flags, output word
  always_ff @(posedge clk) begin
    if (in_acc) begin
      px         <= x0;
      py         <= y0;
      res_inside <= 1'b0;
      res_full   <= (op == pits_pkg::OP_LOAD) && full;
    end
    if (cls.vld) begin
      case (cls.sel)
        pits_pkg::X_A_B, pits_pkg::X_B_A: begin
          g_pos <= cls.pos;
          g_neg <= cls.neg;
        end
        pits_pkg::X_A_C: test_a <= between;
        default: begin
          if (test_a && between) begin
            res_inside <= 1'b1;
          end
        end
      endcase
    end
    if ((state == pits_pkg::ST_RESP) && slot_free) begin
      is_inside  <= res_inside;
      table_full <= res_full;
    end
  end

  // ---------------------------------------------------------------- checks
  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !pipe_busy)
    else $error("input ready while the cross product pipeline still works");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_MAX)
    else $error("fill count beyond table size");

  a_drop_keeps_count: assert property (@(posedge clk) disable iff (rst)
    (in_acc && (op == pits_pkg::OP_LOAD) && full) |=> $stable(count))
    else $error("dropped load changed the fill count");

  a_walk_in_table: assert property (@(posedge clk) disable iff (rst)
    step.vld |-> (tri_cnt < count))
    else $error("walk issued a triangle beyond the fill count");

  a_load_result_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && table_full) |-> !is_inside)
    else $error("dropped load result carries an inside flag");

endmodule

// ----- tb/sv/tb_point_in_triangle_set_unit.sv -----
`timescale 1ns / 1ps
// testbench of the point-in-triangle set unit: random and directed words against a predictor
module tb_point_in_triangle_set_unit;

  localparam int TRI_CAP       = 128;
  localparam int RAND_ITEMS    = 1000;
  // a full-table query with stalls fits well inside this bound on the drain wait
  localparam int DRAIN_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 40;
  // set well above the slowest correct run, in which every word is a full-table query
  localparam int CYCLE_LIMIT   = 5000000;
  localparam int PRINT_CAP     = 100;

  // op 3 has no package code: the block ignores it
  localparam logic [pits_pkg::OP_W-1:0] OP_RESERVED = 2'd3;

  // one input word as driven on the ports
  typedef struct packed {
    logic [pits_pkg::OP_W-1:0]           op;
    logic signed [pits_pkg::COORD_W-1:0] x0;
    logic signed [pits_pkg::COORD_W-1:0] y0;
    logic signed [pits_pkg::COORD_W-1:0] x1;
    logic signed [pits_pkg::COORD_W-1:0] y1;
    logic signed [pits_pkg::COORD_W-1:0] x2;
    logic signed [pits_pkg::COORD_W-1:0] y2;
  } word_t;

  // one expected result word
  typedef struct packed {
    logic hit;
    logic full;
  } answer_t;

  // mirror of the triangle table plus the queue of answers still owed by the block
  class tri_scoreboard;
    logic [pits_pkg::EPS_W-1:0] eps;
    longint                     tri_store [TRI_CAP][pits_pkg::WORDS_PER_TRI];
    int                         tri_count;
    answer_t                    answers_due [$];
    int                         errors;
    int                         checked;
    int                         hits;
    int                         dropped;
    int                         loads;
    int                         queries;
    int                         clears;

    function new();
      eps       = pits_pkg::EPS_RESET;
      tri_count = 0;
    endfunction

    // sign class of ax*by - ay*bx, exact, with the epsilon dead band
    function int cross_class(longint ax, longint ay, longint bx, longint by);
      logic signed [67:0] wide;
      logic [67:0]        size;
      wide = 68'(ax) * 68'(by) - 68'(ay) * 68'(bx);
      size = (wide < 0) ? -wide : wide;
      if (size == 0 || size < 68'(eps)) return 0;
      return (wide < 0) ? -1 : 1;
    endfunction

    // point direction strictly between the edges to u and to v seen from origin o
    function bit strictly_between(longint px, longint py, longint ox, longint oy,
                                  longint ux, longint uy, longint vx, longint vy);
      int g1;
      int g2;
      g1 = cross_class(px - ox, py - oy, ux - ox, uy - oy);
      g2 = cross_class(px - ox, py - oy, vx - ox, vy - oy);
      return (g1 < 0 && g2 > 0) || (g1 > 0 && g2 < 0);
    endfunction

    function logic point_hits(longint px, longint py);
      for (int t = 0; t < tri_count; t++) begin
        if (strictly_between(px, py,
                             tri_store[t][pits_pkg::W_AX], tri_store[t][pits_pkg::W_AY],
                             tri_store[t][pits_pkg::W_BX], tri_store[t][pits_pkg::W_BY],
                             tri_store[t][pits_pkg::W_CX], tri_store[t][pits_pkg::W_CY]) &&
            strictly_between(px, py,
                             tri_store[t][pits_pkg::W_BX], tri_store[t][pits_pkg::W_BY],
                             tri_store[t][pits_pkg::W_AX], tri_store[t][pits_pkg::W_AY],
                             tri_store[t][pits_pkg::W_CX], tri_store[t][pits_pkg::W_CY]))
          return 1'b1;
      end
      return 1'b0;
    endfunction

    // called once per accepted input word
    function void take_word(word_t w);
      answer_t a;
      a = '0;
      case (w.op)
        pits_pkg::OP_CLEAR: begin
          tri_count = 0;
          clears++;
        end
        pits_pkg::OP_LOAD: begin
          loads++;
          if (tri_count >= TRI_CAP) begin
            a.full = 1'b1;
            dropped++;
          end else begin
            tri_store[tri_count][pits_pkg::W_AX] = w.x0;
            tri_store[tri_count][pits_pkg::W_AY] = w.y0;
            tri_store[tri_count][pits_pkg::W_BX] = w.x1;
            tri_store[tri_count][pits_pkg::W_BY] = w.y1;
            tri_store[tri_count][pits_pkg::W_CX] = w.x2;
            tri_store[tri_count][pits_pkg::W_CY] = w.y2;
            tri_count++;
          end
          answers_due.insert(answers_due.size(), a);
        end
        pits_pkg::OP_QUERY: begin
          queries++;
          a.hit = point_hits(w.x0, w.y0);
          answers_due.insert(answers_due.size(), a);
        end
        default: ;
      endcase
    endfunction

    task flag_mismatch(string msg);
      // keep the log short when everything goes wrong
      if (errors < PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    // called once per accepted result word
    task check_answer(logic hit, logic full);
      answer_t a;
      if (answers_due.size() == 0) begin
        flag_mismatch("result word with nothing expected");
      end else begin
        a = answers_due.pop_front();
        checked++;
        if (a.hit) hits++;
        if (hit !== a.hit)
          flag_mismatch($sformatf("is_inside %b, expected %b", hit, a.hit));
        if (full !== a.full)
          flag_mismatch($sformatf("table_full %b, expected %b", full, a.full));
      end
    endtask
  endclass

  logic                                clk = 1'b0;
  logic                                rst;
  logic                                cfg_valid;
  logic                                cfg_ready;
  logic [pits_pkg::EPS_W-1:0]          cfg_data;
  logic                                in_valid;
  logic                                in_ready;
  logic [pits_pkg::OP_W-1:0]           op;
  logic signed [pits_pkg::COORD_W-1:0] x0;
  logic signed [pits_pkg::COORD_W-1:0] y0;
  logic signed [pits_pkg::COORD_W-1:0] x1;
  logic signed [pits_pkg::COORD_W-1:0] y1;
  logic signed [pits_pkg::COORD_W-1:0] x2;
  logic signed [pits_pkg::COORD_W-1:0] y2;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic                                is_inside;
  logic                                table_full;

  tri_scoreboard sb;
  int            cycle_count = 0;
  int            rand_sent = 0;
  int            eps_writes = 0;
  // no random idling on either side while set
  bit            calm = 1'b0;

  point_in_triangle_set_unit #(
    .MAX_TRIANGLES(TRI_CAP)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .x0        (x0),
    .y0        (y0),
    .x1        (x1),
    .y1        (y1),
    .x2        (x2),
    .y2        (y2),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .is_inside (is_inside),
    .table_full(table_full)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side stalls in about 15 percent of cycles unless calm is set
  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= 15);
  end

  // watchdog and result monitor, both on the rising edge
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("point_in_triangle_set_unit verification failed");
      $finish;
    end else if (!rst && out_valid && out_ready) begin
      sb.check_answer(is_inside, table_full);
    end
  end

  function automatic word_t make_word(logic [pits_pkg::OP_W-1:0] code,
                                      logic signed [pits_pkg::COORD_W-1:0] ax,
                                      logic signed [pits_pkg::COORD_W-1:0] ay,
                                      logic signed [pits_pkg::COORD_W-1:0] bx,
                                      logic signed [pits_pkg::COORD_W-1:0] by,
                                      logic signed [pits_pkg::COORD_W-1:0] cx,
                                      logic signed [pits_pkg::COORD_W-1:0] cy);
    word_t w;
    w.op = code;
    w.x0 = ax;
    w.y0 = ay;
    w.x1 = bx;
    w.y1 = by;
    w.x2 = cx;
    w.y2 = cy;
    return w;
  endfunction

  // coordinate draw: 0 any 32 bits, 1 moderate, 2 tiny, else an extreme value
  function automatic logic signed [pits_pkg::COORD_W-1:0] rand_coord(int kind);
    case (kind)
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      2: return $signed($urandom_range(0, 16)) - 32'sd8;
      default: begin
        case ($urandom_range(0, 4))
          0: return 32'sh7fff_ffff;
          1: return 32'sh8000_0000;
          2: return 32'sh7fff_fffe;
          3: return 32'sh8000_0001;
          default: return 32'sh0000_0000;
        endcase
      end
    endcase
  endfunction

  // mostly moderate triangles, some wide, tiny, degenerate or at the corners
  function automatic word_t make_load();
    word_t w;
    int    pick;
    int    kind;
    bit    mix;
    pick = $urandom_range(0, 99);
    kind = (pick < 55) ? 1 : (pick < 70) ? 0 : (pick < 80) ? 2 : (pick < 88) ? 1 : 3;
    mix  = (pick >= 94);
    w.op = pits_pkg::OP_LOAD;
    w.x0 = rand_coord(mix ? int'($urandom_range(0, 3)) : kind);
    w.y0 = rand_coord(mix ? int'($urandom_range(0, 3)) : kind);
    w.x1 = rand_coord(mix ? int'($urandom_range(0, 3)) : kind);
    w.y1 = rand_coord(mix ? int'($urandom_range(0, 3)) : kind);
    w.x2 = rand_coord(mix ? int'($urandom_range(0, 3)) : kind);
    w.y2 = rand_coord(mix ? int'($urandom_range(0, 3)) : kind);
    // degenerate: collinear third vertex or a repeated vertex
    if (pick >= 80 && pick < 88) begin
      if ($urandom_range(0, 1) == 1) begin
        w.x2 = 2 * w.x1 - w.x0;
        w.y2 = 2 * w.y1 - w.y0;
      end else begin
        w.x2 = w.x0;
        w.y2 = w.y0;
      end
    end
    return w;
  endfunction

  // query points: inside, on a vertex, on or near an edge of a stored triangle, or random
  function automatic word_t make_query();
    word_t  w;
    int     mode;
    int     t;
    int     v;
    int     u;
    longint wa;
    longint wb;
    longint wc;
    longint px;
    longint py;
    w.op = pits_pkg::OP_QUERY;
    w.x1 = $urandom;
    w.y1 = $urandom;
    w.x2 = $urandom;
    w.y2 = $urandom;
    mode = $urandom_range(0, 99);
    if (sb.tri_count == 0 || mode >= 75) begin
      w.x0 = rand_coord(mode >= 90 ? 3 : int'($urandom_range(0, 1)));
      w.y0 = rand_coord(mode >= 90 ? 3 : int'($urandom_range(0, 1)));
    end else begin
      t = $urandom_range(0, sb.tri_count - 1);
      v = $urandom_range(0, 2);
      u = (v + 1) % 3;
      if (mode < 45) begin
        // strictly positive weights put the point in the interior
        wa = $urandom_range(1, 1000);
        wb = $urandom_range(1, 1000);
        wc = $urandom_range(1, 1000);
        px = (wa * sb.tri_store[t][pits_pkg::W_AX] + wb * sb.tri_store[t][pits_pkg::W_BX] +
              wc * sb.tri_store[t][pits_pkg::W_CX]) / (wa + wb + wc);
        py = (wa * sb.tri_store[t][pits_pkg::W_AY] + wb * sb.tri_store[t][pits_pkg::W_BY] +
              wc * sb.tri_store[t][pits_pkg::W_CY]) / (wa + wb + wc);
      end else if (mode < 55) begin
        px = sb.tri_store[t][2 * v];
        py = sb.tri_store[t][2 * v + 1];
      end else begin
        px = (sb.tri_store[t][2 * v] + sb.tri_store[t][2 * u]) / 2;
        py = (sb.tri_store[t][2 * v + 1] + sb.tri_store[t][2 * u + 1]) / 2;
        // nudge off the edge by a few lsb so the epsilon band decides
        if (mode >= 65) begin
          px = px + longint'($urandom_range(0, 6)) - 3;
          py = py + longint'($urandom_range(0, 6)) - 3;
        end
      end
      w.x0 = 32'(px);
      w.y0 = 32'(py);
    end
    return w;
  endfunction

  // drives one input word from a falling edge and waits for it to be taken
  task automatic send_word(word_t w);
    calm = (rand_sent >= 300) && (rand_sent < 500);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 15) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    op       <= w.op;
    x0       <= w.x0;
    y0       <= w.y0;
    x1       <= w.x1;
    y1       <= w.y1;
    x2       <= w.x2;
    y2       <= w.y2;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.take_word(w);
  endtask

  task automatic write_eps(logic [pits_pkg::EPS_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.eps = value;
    eps_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // lets every owed result arrive, then waits out the settle time for a trailing clear
  task automatic wait_drained();
    int spins;
    spins = 0;
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.answers_due.size() != 0 && spins < DRAIN_LIMIT) begin
      @(posedge clk);
      spins++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int                         phase;
    int                         pick;
    logic [pits_pkg::EPS_W-1:0] eps_val;
    sb        = new();
    rst       = 1'b1;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    op        = pits_pkg::OP_CLEAR;
    x0        = '0;
    y0        = '0;
    x1        = '0;
    y1        = '0;
    x2        = '0;
    y2        = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed words at the reset epsilon
    // empty table gives outside
    send_word(make_word(pits_pkg::OP_QUERY, 0, 0, $urandom, $urandom, $urandom, $urandom));
    // right triangle with legs of 8.0
    send_word(make_word(pits_pkg::OP_LOAD, 0, 0, 32'sh8000, 0, 0, 32'sh8000));
    send_word(make_word(pits_pkg::OP_QUERY, 32'sh1000, 32'sh1000, 0, 0, 0, 0));
    // vertex, hypotenuse and leg points all count as outside
    send_word(make_word(pits_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0));
    send_word(make_word(pits_pkg::OP_QUERY, 32'sh4000, 32'sh4000, 0, 0, 0, 0));
    send_word(make_word(pits_pkg::OP_QUERY, 32'sh4000, 0, 0, 0, 0, 0));
    // reserved op leaves everything alone
    send_word(make_word(OP_RESERVED, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom));
    send_word(make_word(pits_pkg::OP_QUERY, 32'sh4000, 32'sh3fff, 0, 0, 0, 0));
    // collinear triangle never holds a point
    send_word(make_word(pits_pkg::OP_LOAD, 0, 0, 32'sh1000, 32'sh1000, 32'sh2000,
                        32'sh2000));
    send_word(make_word(pits_pkg::OP_QUERY, 32'sh1000, 32'sh1000, 0, 0, 0, 0));
    // corner triangle: products near 2^64
    send_word(make_word(pits_pkg::OP_LOAD, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff,
                        32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff));
    send_word(make_word(pits_pkg::OP_QUERY, 0, 0, '1, '1, '1, '1));
    send_word(make_word(pits_pkg::OP_QUERY, 32'sh7fff_ffff, 32'sh7fff_ffff, 0, 0, 0, 0));
    send_word(make_word(pits_pkg::OP_QUERY, 32'sh8000_0000, 32'sh8000_0000, 0, 0, 0, 0));
    send_word(make_word(pits_pkg::OP_QUERY, 32'sh8000_0001, 32'sh8000_0001, 0, 0, 0, 0));
    // tiny triangle whose products fall inside the default dead band
    send_word(make_word(pits_pkg::OP_LOAD, 0, 0, 3, 0, 0, 3));
    send_word(make_word(pits_pkg::OP_QUERY, 1, 1, 0, 0, 0, 0));
    // clear empties the table
    send_word(make_word(pits_pkg::OP_CLEAR, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom));
    send_word(make_word(pits_pkg::OP_QUERY, 32'sh1000, 32'sh1000, 0, 0, 0, 0));
    send_word(make_word(pits_pkg::OP_LOAD, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                        32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff));
    send_word(make_word(pits_pkg::OP_LOAD, 0, 0, 3, 0, 0, 3));
    // zero epsilon: only exact zeros are zero, so the tiny triangle holds (1,1)
    wait_drained();
    write_eps('0);
    send_word(make_word(pits_pkg::OP_QUERY, 1, 1, 0, 0, 0, 0));
    wait_drained();
    write_eps('1);
    send_word(make_word(pits_pkg::OP_QUERY, 1, 1, 0, 0, 0, 0));

    // random phases: new epsilon, clear, then a burst of mostly loads and queries
    phase = 0;
    while (rand_sent < RAND_ITEMS) begin
      wait_drained();
      case (phase % 6)
        0:       eps_val = '0;
        1:       eps_val = '1;
        2:       eps_val = 16'd1;
        3:       eps_val = pits_pkg::EPS_RESET;
        4:       eps_val = 16'($urandom_range(0, 4096));
        default: eps_val = 16'($urandom_range(0, 65535));
      endcase
      write_eps(eps_val);
      send_word(make_word(pits_pkg::OP_CLEAR, $urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom));
      rand_sent++;
      if (phase == 2 || phase == 13) begin
        // fill the table and run past the end so loads get dropped
        repeat (TRI_CAP + $urandom_range(1, 4)) begin
          send_word(make_load());
          rand_sent++;
        end
        repeat ($urandom_range(4, 8)) begin
          send_word(make_query());
          rand_sent++;
        end
      end else begin
        repeat ($urandom_range(6, 40)) begin
          pick = $urandom_range(0, 99);
          if (pick < 35) begin
            send_word(make_load());
            rand_sent++;
          end else if (pick < 93) begin
            send_word(make_query());
            rand_sent++;
          end else if (pick < 97) begin
            send_word(make_word(OP_RESERVED, $urandom, $urandom, $urandom, $urandom,
                                $urandom, $urandom));
          end else begin
            send_word(make_word(pits_pkg::OP_CLEAR, $urandom, $urandom, $urandom, $urandom,
                                $urandom, $urandom));
            rand_sent++;
          end
        end
      end
      phase++;
    end

    wait_drained();
    if (sb.answers_due.size() != 0)
      sb.flag_mismatch($sformatf("%0d result words never arrived", sb.answers_due.size()));

    $display("ran %0d loads, %0d queries and %0d clears over %0d phases, %0d results checked",
             sb.loads, sb.queries, sb.clears, phase, sb.checked);
    $display("%0d queries landed inside, %0d loads hit a full table, %0d epsilon writes",
             sb.hits, sb.dropped, eps_writes);
    if (sb.errors == 0) begin
      $display("point_in_triangle_set_unit verification clean");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("point_in_triangle_set_unit verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/pits_pkg.sv
sv/pits_ram.sv
sv/pits_cross_unit.sv
sv/point_in_triangle_set_unit.sv
tb/sv/tb_point_in_triangle_set_unit.sv
